>>> hdl/tftpc_pkg.sv
`default_nettype none
package tftpc_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int HDR_BYTES   = 4;
	localparam int LEN_W       = 10;
	localparam int BLK_W       = 16;
	localparam int TMR_W       = 16;
	localparam int RTY_W       = 4;

	localparam logic [LEN_W-1:0] BLOCK_LEN = LEN_W'(BLOCK_BYTES);
	localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(HDR_BYTES);

	localparam logic [TMR_W-1:0] TIMEOUT_RST = 16'd300;
	localparam logic [RTY_W-1:0] RETRY_RST   = 4'd8;

	localparam logic [15:0] OP_DATA = 16'd3;
	localparam logic [15:0] OP_ACK  = 16'd4;

	typedef enum logic [1:0] {
		CMD_START_WR = 2'd0,
		CMD_START_RD = 2'd1,
		CMD_PKT      = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_RRQ   = 3'd0,
		ACT_WRQ   = 3'd1,
		ACT_DATA  = 3'd2,
		ACT_ACK   = 3'd3,
		ACT_DONE  = 3'd4,
		ACT_ABORT = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_REQ  = 2'd1,
		PH_XFER = 2'd2
	} phase_t;

	typedef enum logic {
		REG_TIMEOUT = 1'b0,
		REG_RETRIES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		action_t          action;
		logic [BLK_W-1:0] block_num;
		logic [LEN_W-1:0] payload_len;
		logic             is_retransmit;
		logic             last;
	} res_t;

	// Results of one processed item, zero to two of them
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage
`default_nettype wire

>>> hdl/tftpc_req_if.sv
`default_nettype none
interface tftpc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] pkt_opcode;
	logic [9:0]  pkt_length;
	logic [9:0]  src_avail;

	modport source (output valid, cmd, pkt_opcode, pkt_length, src_avail, input ready);
	modport sink (input valid, cmd, pkt_opcode, pkt_length, src_avail, output ready);
endinterface
`default_nettype wire

>>> hdl/tftpc_rsp_if.sv
`default_nettype none
interface tftpc_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] block_num;
	logic [9:0]  payload_len;
	logic        is_retransmit;
	logic        last;

	modport source (output valid, action, block_num, payload_len, is_retransmit, last,
		input ready);
	modport sink (input valid, action, block_num, payload_len, is_retransmit, last,
		output ready);
endinterface
`default_nettype wire

>>> hdl/tftpc_cfg_if.sv
`default_nettype none
interface tftpc_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/tftpc_ctrl.sv
`default_nettype none
module tftpc_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	tftpc_req_if.sink         req,
	tftpc_cfg_if.sink         cfg,
	input  wire               room,
	output tftpc_pkg::push_t  push
);

	// Input stage
	logic                             v_s1;
	tftpc_pkg::cmd_t                  cmd_s1;
	logic [15:0]                      opc_s1;
	logic [tftpc_pkg::LEN_W-1:0]      plen_s1;
	logic [tftpc_pkg::LEN_W-1:0]      avail_s1;
	logic                             go;

	// Configuration
	logic [tftpc_pkg::TMR_W-1:0]      timeout_q;
	logic [tftpc_pkg::RTY_W-1:0]      max_retry_q;

	// Transfer state
	tftpc_pkg::phase_t                phase_q, phase_d;
	logic                             is_wr_q, is_wr_d;
	logic [tftpc_pkg::BLK_W-1:0]      send_blk_q, send_blk_d;
	logic [tftpc_pkg::BLK_W-1:0]      recv_blk_q, recv_blk_d;
	logic                             src_end_q, src_end_d;
	logic [tftpc_pkg::LEN_W-1:0]      last_len_q, last_len_d;
	logic [tftpc_pkg::RTY_W-1:0]      retry_q, retry_d;
	logic [tftpc_pkg::TMR_W-1:0]      timer_q, timer_d;

	logic [tftpc_pkg::TMR_W-1:0]      arm_val;
	logic [tftpc_pkg::LEN_W-1:0]      send_len;
	logic [tftpc_pkg::LEN_W-1:0]      pay_raw;
	logic [tftpc_pkg::LEN_W-1:0]      pay;
	logic                             full;
	logic [tftpc_pkg::TMR_W-1:0]      timer_dec;
	tftpc_pkg::res_t                  fin;

	assign go        = v_s1 && room;
	assign req.ready = !v_s1 || room;
	assign cfg.ready = 1'b1;

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1   <= tftpc_pkg::cmd_t'(req.cmd);
			opc_s1   <= req.pkt_opcode;
			plen_s1  <= req.pkt_length;
			avail_s1 <= req.src_avail;
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= tftpc_pkg::TIMEOUT_RST;
			max_retry_q <= tftpc_pkg::RETRY_RST;
		end else if (cfg.valid) begin
			case (tftpc_pkg::reg_idx_t'(cfg.index))
				tftpc_pkg::REG_TIMEOUT: timeout_q   <= cfg.data;
				tftpc_pkg::REG_RETRIES: max_retry_q <= cfg.data[tftpc_pkg::RTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared terms
	assign arm_val   = (timeout_q == '0) ? tftpc_pkg::TMR_W'(1) : timeout_q;
	assign send_len  = (avail_s1 > tftpc_pkg::BLOCK_LEN) ? tftpc_pkg::BLOCK_LEN : avail_s1;
	assign pay_raw   = (plen_s1 >= tftpc_pkg::HDR_LEN) ? (plen_s1 - tftpc_pkg::HDR_LEN) : '0;
	assign full      = (pay_raw >= tftpc_pkg::BLOCK_LEN);
	assign pay       = full ? tftpc_pkg::BLOCK_LEN : pay_raw;
	assign timer_dec = timer_q - tftpc_pkg::TMR_W'(1);

	always_comb begin
		fin               = '0;
		fin.action        = tftpc_pkg::ACT_DONE;
		fin.last          = 1'b1;
	end

	// Decode one transaction against the transfer state
	always_comb begin
		phase_d    = phase_q;
		is_wr_d    = is_wr_q;
		send_blk_d = send_blk_q;
		recv_blk_d = recv_blk_q;
		src_end_d  = src_end_q;
		last_len_d = last_len_q;
		retry_d    = retry_q;
		timer_d    = timer_q;
		push       = '0;

		case (cmd_s1)
			tftpc_pkg::CMD_START_WR, tftpc_pkg::CMD_START_RD: begin
				is_wr_d          = (cmd_s1 == tftpc_pkg::CMD_START_WR);
				send_blk_d       = tftpc_pkg::BLK_W'(1);
				recv_blk_d       = tftpc_pkg::BLK_W'(1);
				src_end_d        = 1'b0;
				last_len_d       = '0;
				retry_d          = '0;
				phase_d          = tftpc_pkg::PH_REQ;
				timer_d          = arm_val;
				push.cnt         = 2'd1;
				push.r0.action   = (cmd_s1 == tftpc_pkg::CMD_START_WR) ?
					tftpc_pkg::ACT_WRQ : tftpc_pkg::ACT_RRQ;
				push.r0.last     = 1'b1;
			end
			tftpc_pkg::CMD_PKT: begin
				if (phase_q != tftpc_pkg::PH_IDLE) begin
					push.cnt = 2'd1;
					if (is_wr_q) begin
						if (phase_q == tftpc_pkg::PH_REQ ||
								(opc_s1 == tftpc_pkg::OP_ACK && !src_end_q)) begin
							// Send next data block
							retry_d             = '0;
							last_len_d          = send_len;
							src_end_d           = (send_len < tftpc_pkg::BLOCK_LEN);
							push.r0.action      = tftpc_pkg::ACT_DATA;
							push.r0.block_num   = send_blk_q;
							push.r0.payload_len = send_len;
							push.r0.last        = 1'b1;
							send_blk_d          = send_blk_q + tftpc_pkg::BLK_W'(1);
							phase_d             = tftpc_pkg::PH_XFER;
							timer_d             = arm_val;
						end else begin
							if (opc_s1 == tftpc_pkg::OP_ACK) begin
								retry_d = '0;
								push.r0 = fin;
							end else begin
								push.r0        = fin;
								push.r0.action = tftpc_pkg::ACT_ABORT;
							end
							phase_d = tftpc_pkg::PH_IDLE;
							timer_d = '0;
						end
					end else if (opc_s1 != tftpc_pkg::OP_DATA) begin
						push.r0        = fin;
						push.r0.action = tftpc_pkg::ACT_ABORT;
						phase_d        = tftpc_pkg::PH_IDLE;
						timer_d        = '0;
					end else begin
						// Acknowledge data; a short block also ends the read
						retry_d             = '0;
						push.r0.action      = tftpc_pkg::ACT_ACK;
						push.r0.block_num   = recv_blk_q;
						push.r0.payload_len = pay;
						push.r0.last        = full;
						recv_blk_d          = recv_blk_q + tftpc_pkg::BLK_W'(1);
						if (full) begin
							phase_d = tftpc_pkg::PH_XFER;
							timer_d = arm_val;
						end else begin
							push.cnt = 2'd2;
							push.r1  = fin;
							phase_d  = tftpc_pkg::PH_IDLE;
							timer_d  = '0;
						end
					end
				end
			end
			tftpc_pkg::CMD_TICK: begin
				if (phase_q != tftpc_pkg::PH_IDLE && timer_q != '0) begin
					timer_d = timer_dec;
					if (timer_dec == '0) begin
						push.cnt = 2'd1;
						if (retry_q >= max_retry_q) begin
							push.r0        = fin;
							push.r0.action = tftpc_pkg::ACT_ABORT;
							phase_d        = tftpc_pkg::PH_IDLE;
						end else begin
							// Resend the last packet
							retry_d               = retry_q + tftpc_pkg::RTY_W'(1);
							timer_d               = arm_val;
							push.r0.is_retransmit = 1'b1;
							push.r0.last          = 1'b1;
							if (phase_q == tftpc_pkg::PH_REQ) begin
								push.r0.action = is_wr_q ?
									tftpc_pkg::ACT_WRQ : tftpc_pkg::ACT_RRQ;
							end else if (is_wr_q) begin
								push.r0.action      = tftpc_pkg::ACT_DATA;
								push.r0.block_num   = send_blk_q - tftpc_pkg::BLK_W'(1);
								push.r0.payload_len = last_len_q;
							end else begin
								push.r0.action    = tftpc_pkg::ACT_ACK;
								push.r0.block_num = recv_blk_q - tftpc_pkg::BLK_W'(1);
							end
						end
					end
				end
			end
			default: ;
		endcase

		if (!go) begin
			push.cnt = 2'd0;
		end
	end

	// Advance the transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tftpc_pkg::PH_IDLE;
			is_wr_q    <= 1'b0;
			send_blk_q <= tftpc_pkg::BLK_W'(1);
			recv_blk_q <= tftpc_pkg::BLK_W'(1);
			src_end_q  <= 1'b0;
			last_len_q <= '0;
			retry_q    <= '0;
			timer_q    <= '0;
		end else if (go) begin
			phase_q    <= phase_d;
			is_wr_q    <= is_wr_d;
			send_blk_q <= send_blk_d;
			recv_blk_q <= recv_blk_d;
			src_end_q  <= src_end_d;
			last_len_q <= last_len_d;
			retry_q    <= retry_d;
			timer_q    <= timer_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/tftpc_outq.sv
`default_nettype none
module tftpc_outq (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire tftpc_pkg::push_t  push,
	output logic                   room,
	tftpc_rsp_if.source            rsp
);

	tftpc_pkg::res_t  mem_q [4];
	logic [1:0]       wp_q;
	logic [1:0]       rp_q;
	logic [2:0]       cnt_q;
	logic             pop;
	tftpc_pkg::res_t  head;

	assign pop  = rsp.valid && rsp.ready;
	assign room = (cnt_q <= 3'd2);
	assign head = mem_q[rp_q];

	assign rsp.valid         = (cnt_q != 3'd0);
	assign rsp.action        = head.action;
	assign rsp.block_num     = head.block_num;
	assign rsp.payload_len   = head.payload_len;
	assign rsp.is_retransmit = head.is_retransmit;
	assign rsp.last          = head.last;

	// Store up to two results per cycle
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wp_q + 2'd1] <= push.r1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push.cnt;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.cnt} - {2'b0, pop};
		end
	end

endmodule
`default_nettype wire

>>> hdl/tftp_client_transfer_control_core.sv
`default_nettype none
// TFTP client transfer controller.
// req carries one event per transaction: start write, start read, packet
// received (opcode, length) or timer tick, plus the bytes the local source
// has for the next data block. rsp carries the packets to send and the
// done/abort indications; last marks the final result of one event.
// cfg writes timeout_ticks (index 0) and max_retries (index 1); it is always
// ready and should be written only while no event is in flight.
// An event is registered in the input stage and its results are written into
// the output queue, from which rsp presents them.
// Throughput: one event per cycle. A short read data packet yields two
// results (ack, done), which leave one at a time on rsp through a
// four-entry output queue; the input stage holds while that queue holds
// three or more results.
// When rsp stalls, results stay queued, then the input stage holds, then
// req.ready goes low; nothing is dropped.
// Reset clears the transfer to idle, disarms the timer and restores
// timeout_ticks to 300 and max_retries to 8.
module tftp_client_transfer_control_core (
	input  wire          clk,
	input  wire          arst_n,
	tftpc_req_if.sink    req,
	tftpc_rsp_if.source  rsp,
	tftpc_cfg_if.sink    cfg
);

	tftpc_pkg::push_t  push;
	logic              room;

	tftpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	tftpc_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
